// ===== hdl/nsr_pkg.sv =====
package nsr_pkg;

  // Fixed width of operand and root
  localparam int ROOT_W = 32;

  // Default configuration
  localparam int DEF_ITERATIONS = 10;
  localparam int DEF_FRAC_BITS  = 16;

  // Saturation value of one Newton step
  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

endpackage

// ===== hdl/nsr_cell.sv =====
module nsr_cell import nsr_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int BIT       = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ROOT_W-1:0]             operand_i,
  input  logic [ROOT_W-1:0]             x_i,
  input  logic [ROOT_W:0]               rem_i,
  input  logic [ROOT_W+FRAC_BITS-1:0]   quot_i,
  output logic                          valid_o,
  output logic [ROOT_W-1:0]             operand_o,
  output logic [ROOT_W-1:0]             x_o,
  output logic [ROOT_W:0]               rem_o,
  output logic [ROOT_W+FRAC_BITS-1:0]   quot_o
);

  localparam int SW = ROOT_W + FRAC_BITS;

  logic              nbit;
  logic [ROOT_W:0]   rem_in;
  logic [SW-1:0]     quot_in;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W+1:0] denom;
  logic [ROOT_W+1:0] diff;
  logic              ge;
  logic [ROOT_W:0]   rem_d;
  logic [SW-1:0]     quot_d;
  logic [SW:0]       sum;
  logic [ROOT_W-1:0] x_d;

  logic              valid_q;
  logic [ROOT_W-1:0] operand_q;
  logic [ROOT_W-1:0] x_q;
  logic [ROOT_W:0]   rem_q;
  logic [SW-1:0]     quot_q;

  // Pick the dividend bit of operand << FRAC_BITS
  if (BIT >= FRAC_BITS) begin : g_op_bit
    assign nbit = operand_i[BIT-FRAC_BITS];
  end else begin : g_zero_bit
    assign nbit = 1'b0;
  end

  // Start a fresh division at the top bit
  if (BIT == SW-1) begin : g_first
    assign rem_in  = '0;
    assign quot_in = '0;
  end else begin : g_pass
    assign rem_in  = rem_i;
    assign quot_in = quot_i;
  end

  // One restoring division step against 2x
  assign trial  = {rem_in, nbit};
  assign denom  = {1'b0, x_i, 1'b0};
  assign ge     = (trial >= denom);
  assign diff   = trial - denom;
  assign rem_d  = ge ? diff[ROOT_W:0] : trial[ROOT_W:0];
  assign quot_d = {quot_in[SW-2:0], ge};

  // Close the Newton step on the last bit: x/2 + quotient, saturating; a zero estimate stays zero
  assign sum = {{(SW-ROOT_W+2){1'b0}}, x_i[ROOT_W-1:1]} + {1'b0, quot_d};
  if (BIT == 0) begin : g_update
    always_comb begin
      if (x_i == '0) begin
        x_d = '0;
      end else if (sum[SW:ROOT_W] != '0) begin
        x_d = ROOT_MAX;
      end else begin
        x_d = sum[ROOT_W-1:0];
      end
    end
  end else begin : g_hold
    assign x_d = x_i;
  end

  // Advance the transaction flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      operand_q <= operand_i;
      x_q       <= x_d;
      rem_q     <= rem_d;
      quot_q    <= quot_d;
    end
  end

  assign valid_o   = valid_q;
  assign operand_o = operand_q;
  assign x_o       = x_q;
  assign rem_o     = rem_q;
  assign quot_o    = quot_q;

endmodule

// ===== hdl/newton_square_root_top.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o   | operand_i [31:0], Q16.16
// out     | output    | out_valid_o/out_ready_i | root_o [31:0], Q16.16
//
// One transaction enters per cycle while the chain is not stalled. Each
// Newton step is a row of cells, one quotient bit per cell, the last cell
// of a row closing the step.
// Reset clears only the valid flags of the cells.
// A result not taken stalls the whole chain; the chain keeps accepting
// while the last cell is empty or is being drained.
module newton_square_root_top import nsr_pkg::*; #(
  parameter int ITERATIONS = DEF_ITERATIONS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ROOT_W-1:0] operand_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int SW = ROOT_W + FRAC_BITS;
  localparam int NS = ITERATIONS * SW;

  logic              en;
  logic              v   [NS+1];
  logic [ROOT_W-1:0] opnd[NS+1];
  logic [ROOT_W-1:0] x   [NS+1];
  logic [ROOT_W:0]   rem [NS+1];
  logic [SW-1:0]     quot[NS+1];

  // Stall the chain only when the result waits
  assign en         = !v[NS] || out_ready_i;
  assign in_ready_o = en;

  // Feed the chain; the estimate starts at the operand
  assign v[0]    = in_valid_i;
  assign opnd[0] = operand_i;
  assign x[0]    = operand_i;
  assign rem[0]  = '0;
  assign quot[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_cell
    nsr_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (SW - 1 - (k % SW))
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (v[k]),
      .operand_i (opnd[k]),
      .x_i       (x[k]),
      .rem_i     (rem[k]),
      .quot_i    (quot[k]),
      .valid_o   (v[k+1]),
      .operand_o (opnd[k+1]),
      .x_o       (x[k+1]),
      .rem_o     (rem[k+1]),
      .quot_o    (quot[k+1])
    );
  end

  assign out_valid_o = v[NS];
  assign root_o      = x[NS];

endmodule

// ===== hdl/nsr_checker.sv =====
module nsr_checker import nsr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [ROOT_W-1:0] operand_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ROOT_W-1:0] root_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_root_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(root_o))
    else $error("result changed while stalled");

  // Accept whenever the output side can move
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

endmodule

bind newton_square_root_top nsr_checker u_nsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operand_i   (operand_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .root_o      (root_o)
);
